### design/lgci_pkg.sv
package lgci_pkg;

  // Coordinate and fraction formats.
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int F_W        = FRAC_BITS + 1;
  localparam int CHAN_W     = 8;
  localparam int NUM_CHAN   = 3;
  localparam int COLOR_W    = CHAN_W * NUM_CHAN;
  localparam int PROD_W     = CHAN_W + F_W;

  localparam logic [F_W-1:0] F_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // Per-beat side information that rides along the divider.
  typedef struct packed {
    logic [COLOR_W-1:0] src;
    logic [COLOR_W-1:0] dst;
    logic               frc;
    logic               frc_one;
  } meta_t;

endpackage

### design/line_gradient_color_interp.sv
// Linear RGB color interpolation for the pixels of a rasterized line.
// Input channel: in_valid_i / in_ready_o carry one beat per pixel with the
// line's start and end points, the pixel position, the start, end and current
// colors and the major-axis flag. Output channel: out_valid_o / out_ready_i
// carry one beat with the blended RGB888 color, one per input beat, in order.
// The fraction along the major axis is produced by a restoring divider that
// resolves one quotient bit per pipeline stage, so its depth follows FRAC_BITS.
// The pipeline is 3 front stages, FRAC_BITS divider stages and 2 blend stages.
// Throughput is one beat per cycle while the output is not stalled; every
// stage holds at most one beat.
// When the receiver stalls a pending result, the whole pipeline holds in place
// and in_ready_o drops; nothing is lost or repeated, and it resumes on the
// cycle the result is taken. Reset clears every stage valid bit, so the block
// comes out of reset empty and ready; data registers are not reset.
module line_gradient_color_interp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [lgci_pkg::COORD_BITS-1:0]  src_x_i,
  input  logic [lgci_pkg::COORD_BITS-1:0]  src_y_i,
  input  logic [lgci_pkg::COORD_BITS-1:0]  dst_x_i,
  input  logic [lgci_pkg::COORD_BITS-1:0]  dst_y_i,
  input  logic [lgci_pkg::COORD_BITS-1:0]  cur_x_i,
  input  logic [lgci_pkg::COORD_BITS-1:0]  cur_y_i,
  input  logic [lgci_pkg::COLOR_W-1:0]     src_color_i,
  input  logic [lgci_pkg::COLOR_W-1:0]     dst_color_i,
  input  logic [lgci_pkg::COLOR_W-1:0]     cur_color_i,
  input  logic                             x_major_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [lgci_pkg::COLOR_W-1:0]     pixel_color_o
);
  import lgci_pkg::*;

  logic              adv;
  logic              fr_vld, div_vld;
  logic [DIFF_W-1:0] fr_nm, fr_dm;
  meta_t             fr_meta, div_meta;
  logic [F_W-1:0]    div_f;

  // The pipeline moves as one: it advances unless a finished result is
  // waiting at the output register and the receiver is not taking it.
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // Axis selection, differences, magnitudes and the cases that need no
  // division (color already at the end, zero span, before start, past end).
  lgci_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (in_valid_i),
    .src_x_i     (src_x_i),
    .src_y_i     (src_y_i),
    .dst_x_i     (dst_x_i),
    .dst_y_i     (dst_y_i),
    .cur_x_i     (cur_x_i),
    .cur_y_i     (cur_y_i),
    .src_color_i (src_color_i),
    .dst_color_i (dst_color_i),
    .cur_color_i (cur_color_i),
    .x_major_i   (x_major_i),
    .valid_o     (fr_vld),
    .nm_o        (fr_nm),
    .dm_o        (fr_dm),
    .meta_o      (fr_meta)
  );

  // Fraction in Q1.FRAC_BITS; a pixel whose color is already the end color
  // is forced to one, which makes the blend return the end color exactly.
  lgci_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (fr_vld),
    .nm_i    (fr_nm),
    .dm_i    (fr_dm),
    .meta_i  (fr_meta),
    .valid_o (div_vld),
    .f_o     (div_f),
    .meta_o  (div_meta)
  );

  // Per-channel blend: products in one stage, sum and truncation in the
  // output register stage.
  lgci_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (div_vld),
    .f_i     (div_f),
    .src_i   (div_meta.src),
    .dst_i   (div_meta.dst),
    .valid_o (out_valid_o),
    .color_o (pixel_color_o)
  );

`ifndef NO_ASSERTIONS
  // The fraction never exceeds one.
  a_f_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_vld |-> (div_f <= F_ONE))
    else $error("fraction above one");

  // A real division only happens for numerator below denominator.
  a_quot_below_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_vld && !div_meta.frc) |-> (div_f < F_ONE))
    else $error("quotient reached one");

  // Input is refused only while a result waits at the output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no pending output");
`endif

endmodule

### design/lgci_front.sv
module lgci_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             adv_i,
  input  logic                             in_valid_i,
  input  logic [lgci_pkg::COORD_BITS-1:0]  src_x_i,
  input  logic [lgci_pkg::COORD_BITS-1:0]  src_y_i,
  input  logic [lgci_pkg::COORD_BITS-1:0]  dst_x_i,
  input  logic [lgci_pkg::COORD_BITS-1:0]  dst_y_i,
  input  logic [lgci_pkg::COORD_BITS-1:0]  cur_x_i,
  input  logic [lgci_pkg::COORD_BITS-1:0]  cur_y_i,
  input  logic [lgci_pkg::COLOR_W-1:0]     src_color_i,
  input  logic [lgci_pkg::COLOR_W-1:0]     dst_color_i,
  input  logic [lgci_pkg::COLOR_W-1:0]     cur_color_i,
  input  logic                             x_major_i,
  output logic                             valid_o,
  output logic [lgci_pkg::DIFF_W-1:0]      nm_o,
  output logic [lgci_pkg::DIFF_W-1:0]      dm_o,
  output lgci_pkg::meta_t                  meta_o
);
  import lgci_pkg::*;

  logic [COORD_BITS-1:0] st_c, en_c, cu_c;
  logic signed [DIFF_W-1:0] num_d, den_d;

  logic                     s1_vld_q, s2_vld_q, s3_vld_q;
  logic signed [DIFF_W-1:0] s1_num_q, s1_den_q;
  logic                     s1_keep_q;
  logic [COLOR_W-1:0]       s1_src_q, s1_dst_q, s2_src_q, s2_dst_q;
  logic [DIFF_W-1:0]        s2_nm_q, s2_dm_q, s3_nm_q, s3_dm_q;
  logic                     s2_one_q, s2_zero_q;
  logic                     ge_c;
  meta_t                    s3_meta_q;

  // Stage 1: pick the major axis and take both differences.
  always_comb begin
    st_c  = x_major_i ? src_x_i : src_y_i;
    en_c  = x_major_i ? dst_x_i : dst_y_i;
    cu_c  = x_major_i ? cur_x_i : cur_y_i;
    num_d = $signed({cu_c[COORD_BITS-1], cu_c}) - $signed({st_c[COORD_BITS-1], st_c});
    den_d = $signed({en_c[COORD_BITS-1], en_c}) - $signed({st_c[COORD_BITS-1], st_c});
  end

  assign ge_c = s2_nm_q >= s2_dm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (adv_i) begin
      s1_vld_q <= in_valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_num_q  <= num_d;
      s1_den_q  <= den_d;
      s1_keep_q <= (cur_color_i == dst_color_i);
      s1_src_q  <= src_color_i;
      s1_dst_q  <= dst_color_i;

      // Stage 2: magnitudes and the cases that need no division.
      s2_nm_q   <= s1_num_q[DIFF_W-1] ? DIFF_W'(-s1_num_q) : DIFF_W'(s1_num_q);
      s2_dm_q   <= s1_den_q[DIFF_W-1] ? DIFF_W'(-s1_den_q) : DIFF_W'(s1_den_q);
      s2_one_q  <= s1_keep_q || (s1_den_q == '0);
      s2_zero_q <= (s1_num_q == '0) || (s1_num_q[DIFF_W-1] != s1_den_q[DIFF_W-1]);
      s2_src_q  <= s1_src_q;
      s2_dst_q  <= s1_dst_q;

      // Stage 3: a pixel at or past the end saturates to one, one before the start to zero.
      s3_nm_q           <= s2_nm_q;
      s3_dm_q           <= s2_dm_q;
      s3_meta_q.src     <= s2_src_q;
      s3_meta_q.dst     <= s2_dst_q;
      s3_meta_q.frc     <= s2_one_q || s2_zero_q || ge_c;
      s3_meta_q.frc_one <= s2_one_q || (!s2_zero_q && ge_c);
    end
  end

  assign valid_o = s3_vld_q;
  assign nm_o    = s3_nm_q;
  assign dm_o    = s3_dm_q;
  assign meta_o  = s3_meta_q;

endmodule

### design/lgci_div.sv
module lgci_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        valid_i,
  input  logic [lgci_pkg::DIFF_W-1:0] nm_i,
  input  logic [lgci_pkg::DIFF_W-1:0] dm_i,
  input  lgci_pkg::meta_t             meta_i,
  output logic                        valid_o,
  output logic [lgci_pkg::F_W-1:0]    f_o,
  output lgci_pkg::meta_t             meta_o
);
  import lgci_pkg::*;

  logic                 vld_q  [FRAC_BITS];
  logic [DIFF_W-1:0]    rem_q  [FRAC_BITS];
  logic [DIFF_W-1:0]    dm_q   [FRAC_BITS];
  logic [FRAC_BITS-1:0] quo_q  [FRAC_BITS];
  meta_t                meta_q [FRAC_BITS];

  // One restoring step per stage, most significant quotient bit first.
  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_step
    logic                 vld_in;
    logic [DIFF_W-1:0]    rem_in, dm_in;
    logic [FRAC_BITS-1:0] quo_in;
    meta_t                meta_in;
    logic [DIFF_W:0]      r2, diff;
    logic                 take;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = nm_i;
      assign dm_in   = dm_i;
      assign quo_in  = '0;
      assign meta_in = meta_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign dm_in   = dm_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign meta_in = meta_q[k-1];
    end

    assign r2   = {rem_in, 1'b0};
    assign diff = r2 - {1'b0, dm_in};
    assign take = r2 >= {1'b0, dm_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (adv_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k]  <= take ? diff[DIFF_W-1:0] : r2[DIFF_W-1:0];
        dm_q[k]   <= dm_in;
        quo_q[k]  <= {quo_in[FRAC_BITS-2:0], take};
        meta_q[k] <= meta_in;
      end
    end
  end

  assign valid_o = vld_q[FRAC_BITS-1];
  assign meta_o  = meta_q[FRAC_BITS-1];
  assign f_o     = meta_q[FRAC_BITS-1].frc
                   ? (meta_q[FRAC_BITS-1].frc_one ? F_ONE : '0)
                   : {1'b0, quo_q[FRAC_BITS-1]};

endmodule

### design/lgci_blend.sv
module lgci_blend (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         valid_i,
  input  logic [lgci_pkg::F_W-1:0]     f_i,
  input  logic [lgci_pkg::COLOR_W-1:0] src_i,
  input  logic [lgci_pkg::COLOR_W-1:0] dst_i,
  output logic                         valid_o,
  output logic [lgci_pkg::COLOR_W-1:0] color_o
);
  import lgci_pkg::*;

  logic [F_W-1:0]     inv_c;
  logic               p_vld_q, o_vld_q;
  logic [PROD_W-1:0]  ps_q [NUM_CHAN];
  logic [PROD_W-1:0]  pd_q [NUM_CHAN];
  logic [COLOR_W-1:0] color_d, color_q;
  logic [PROD_W:0]    sum_c [NUM_CHAN];

  assign inv_c = F_ONE - f_i;

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      sum_c[c] = {1'b0, ps_q[c]} + {1'b0, pd_q[c]};
      color_d[c*CHAN_W +: CHAN_W] = sum_c[c][FRAC_BITS +: CHAN_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else if (adv_i) begin
      p_vld_q <= valid_i;
      o_vld_q <= p_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        ps_q[c] <= PROD_W'(src_i[c*CHAN_W +: CHAN_W]) * PROD_W'(inv_c);
        pd_q[c] <= PROD_W'(dst_i[c*CHAN_W +: CHAN_W]) * PROD_W'(f_i);
      end
      color_q <= color_d;
    end
  end

  assign valid_o = o_vld_q;
  assign color_o = color_q;

endmodule

### tb/sv/lgci_color_checker.sv
`timescale 1ns / 1ps

module lgci_color_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [lgci_pkg::COORD_BITS-1:0] src_x_i,
  input  logic [lgci_pkg::COORD_BITS-1:0] src_y_i,
  input  logic [lgci_pkg::COORD_BITS-1:0] dst_x_i,
  input  logic [lgci_pkg::COORD_BITS-1:0] dst_y_i,
  input  logic [lgci_pkg::COORD_BITS-1:0] cur_x_i,
  input  logic [lgci_pkg::COORD_BITS-1:0] cur_y_i,
  input  logic [lgci_pkg::COLOR_W-1:0]    src_color_i,
  input  logic [lgci_pkg::COLOR_W-1:0]    dst_color_i,
  input  logic [lgci_pkg::COLOR_W-1:0]    cur_color_i,
  input  logic                            x_major_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [lgci_pkg::COLOR_W-1:0]    pixel_color_i,
  output int                              mismatches_o,
  output int                              outstanding_o,
  output int                              checked_o
);
  import lgci_pkg::*;

  logic [COLOR_W-1:0] expected_colors [$];
  logic [COLOR_W-1:0] want;
  int                 mismatches = 0;
  int                 checked = 0;
  int                 outstanding = 0;

  assign mismatches_o  = mismatches;
  assign outstanding_o = outstanding;
  assign checked_o     = checked;

  // Position along the major axis as unsigned Q1.FRAC_BITS, clamped to [0, 1].
  function automatic logic [F_W-1:0] axis_fraction(input logic [COORD_BITS-1:0] p0,
                                                   input logic [COORD_BITS-1:0] p1,
                                                   input logic [COORD_BITS-1:0] pc);
    longint num, den, nm, dm, q;
    num = longint'($signed(pc)) - longint'($signed(p0));
    den = longint'($signed(p1)) - longint'($signed(p0));
    if (den == 0) return F_ONE;
    if (num == 0) return '0;
    if ((num < 0) != (den < 0)) return '0;
    nm = (num < 0) ? -num : num;
    dm = (den < 0) ? -den : den;
    if (nm >= dm) return F_ONE;
    q = (nm << FRAC_BITS) / dm;
    return F_W'(q);
  endfunction

  function automatic logic [CHAN_W-1:0] mix_channel(input logic [CHAN_W-1:0] s,
                                                    input logic [CHAN_W-1:0] d,
                                                    input logic [F_W-1:0]    f);
    longint acc;
    acc = longint'(s) * ((longint'(1) << FRAC_BITS) - longint'(f)) + longint'(d) * longint'(f);
    return CHAN_W'(acc >> FRAC_BITS);
  endfunction

  function automatic logic [COLOR_W-1:0] line_blend_color();
    logic [F_W-1:0]     f;
    logic [COLOR_W-1:0] mixed;
    if (cur_color_i == dst_color_i) return cur_color_i;
    f = x_major_i ? axis_fraction(src_x_i, dst_x_i, cur_x_i)
                  : axis_fraction(src_y_i, dst_y_i, cur_y_i);
    for (int c = 0; c < NUM_CHAN; c++) begin
      mixed[c*CHAN_W +: CHAN_W] = mix_channel(src_color_i[c*CHAN_W +: CHAN_W],
                                              dst_color_i[c*CHAN_W +: CHAN_W], f);
    end
    return mixed;
  endfunction

  // Results are retired before new pixels are queued, so a beat leaving and
  // one entering on the same edge never pair up.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        checked++;
        if (expected_colors.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected color beat %06h", $realtime, pixel_color_i);
        end else begin
          want = expected_colors.pop_front();
          if (pixel_color_i !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: pixel_color expected %06h got %06h",
                       $realtime, want, pixel_color_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) expected_colors.push_back(line_blend_color());
      outstanding = expected_colors.size();
    end
  end

endmodule

### tb/sv/line_gradient_color_interp_tb.sv
`timescale 1ns / 1ps

module line_gradient_color_interp_tb;
  import lgci_pkg::*;

  // The run ends here at the latest; a correct run needs far fewer cycles.
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BEATS = 700;
  localparam int LONG_HOLD    = 120;
  // Pipeline depth is 3 + FRAC_BITS + 2 stages; allow some margin on top.
  localparam int SETTLE       = 3 + FRAC_BITS + 2 + 20;

  typedef struct packed {
    logic [COORD_BITS-1:0] sx, sy, dx, dy, cx, cy;
    logic [COLOR_W-1:0]    src, dst, cur;
    logic                  xm;
  } pixel_t;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [COORD_BITS-1:0] src_x = '0, src_y = '0, dst_x = '0, dst_y = '0;
  logic [COORD_BITS-1:0] cur_x = '0, cur_y = '0;
  logic [COLOR_W-1:0]    src_color = '0, dst_color = '0, cur_color = '0;
  logic                  x_major = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [COLOR_W-1:0]    pixel_color;

  // Handshake between the stimulus and the receiver for the long hold-off.
  logic                  hold_req = 1'b0;
  bit                    hold_done;

  int mismatches, outstanding, checked;
  int pixels_sent = 0;
  int directed_sent = 0;
  int cycles = 0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  line_gradient_color_interp dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .src_x_i       (src_x),
    .src_y_i       (src_y),
    .dst_x_i       (dst_x),
    .dst_y_i       (dst_y),
    .cur_x_i       (cur_x),
    .cur_y_i       (cur_y),
    .src_color_i   (src_color),
    .dst_color_i   (dst_color),
    .cur_color_i   (cur_color),
    .x_major_i     (x_major),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .pixel_color_o (pixel_color)
  );

  lgci_color_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .src_x_i       (src_x),
    .src_y_i       (src_y),
    .dst_x_i       (dst_x),
    .dst_y_i       (dst_y),
    .cur_x_i       (cur_x),
    .cur_y_i       (cur_y),
    .src_color_i   (src_color),
    .dst_color_i   (dst_color),
    .cur_color_i   (cur_color),
    .x_major_i     (x_major),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .pixel_color_i (pixel_color),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .checked_o     (checked)
  );

  // Clamp an integer position to the signed coordinate range.
  function automatic logic [COORD_BITS-1:0] coord_of(input int v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return COORD_BITS'(v);
  endfunction

  function automatic pixel_t make_pixel(input int sx, sy, dx, dy, cx, cy,
                                        input logic [COLOR_W-1:0] src, dst, cur,
                                        input logic xm);
    pixel_t p;
    p.sx = coord_of(sx);
    p.sy = coord_of(sy);
    p.dx = coord_of(dx);
    p.dy = coord_of(dy);
    p.cx = coord_of(cx);
    p.cy = coord_of(cy);
    p.src = src;
    p.dst = dst;
    p.cur = cur;
    p.xm = xm;
    return p;
  endfunction

  // A pixel the way a rasterizer emits it: a line of mostly short span, a
  // position somewhere along it (now and then off either end) and a major-axis
  // flag that usually matches the longer side. About one in seven beats is
  // plain noise across every bit of every field.
  function automatic pixel_t random_pixel();
    pixel_t p;
    int sx, sy, dx, dy, span, t, pick;
    logic [COLOR_W-1:0] src, dst, cur;
    logic xm;
    logic [6*32-1:0] noise;
    if ($urandom_range(0, 6) == 0) begin
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      p = noise[$bits(pixel_t)-1:0];
      return p;
    end
    pick = $urandom_range(0, 9);
    span = (pick < 5) ? 40 : (pick < 8) ? 2000 : 65535;
    sx = int'($urandom_range(0, 65535)) - 32768;
    sy = int'($urandom_range(0, 65535)) - 32768;
    dx = int'($signed(coord_of(sx + int'($urandom_range(0, 2 * span)) - span)));
    dy = int'($signed(coord_of(sy + int'($urandom_range(0, 2 * span)) - span)));
    if ($urandom_range(0, 9) == 0) t = int'($urandom_range(0, 384)) - 64;
    else t = $urandom_range(0, 256);
    xm = ((dx > sx ? dx - sx : sx - dx) > (dy > sy ? dy - sy : sy - dy));
    if ($urandom_range(0, 15) == 0) xm = ~xm;
    src = COLOR_W'($urandom);
    dst = COLOR_W'($urandom);
    case ($urandom_range(0, 5))
      0: cur = dst;
      1: cur = src;
      default: cur = COLOR_W'($urandom);
    endcase
    return make_pixel(sx, sy, dx, dy, sx + (t * (dx - sx)) / 256,
                      sy + (t * (dy - sy)) / 256, src, dst, cur, xm);
  endfunction

  // Offer one beat at the falling edge and hold it until the block takes it.
  task automatic send_pixel(input pixel_t p);
    @(negedge clk_i);
    {src_x, src_y, dst_x, dst_y, cur_x, cur_y} = {p.sx, p.sy, p.dx, p.dy, p.cx, p.cy};
    {src_color, dst_color, cur_color, x_major} = {p.src, p.dst, p.cur, p.xm};
    in_valid = 1'b1;
    do @(posedge clk_i); while (!in_ready);
    pixels_sent++;
  endtask

  task automatic pause_sender(input int n);
    if (n > 0) begin
      @(negedge clk_i);
      in_valid = 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // Receiver: stretches of steady, light and heavy back-pressure, plus one
  // long hold-off on request, timed here so the pipeline fills and blocks.
  initial begin
    int mode, len;
    @(posedge rst_ni);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        @(negedge clk_i);
        out_ready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
      end else begin
        mode = $urandom_range(0, 3);
        len = $urandom_range(10, 60);
        repeat (len) begin
          @(negedge clk_i);
          case (mode)
            0: out_ready = 1'b1;
            1: out_ready = 1'($urandom_range(0, 1));
            2: out_ready = ($urandom_range(0, 9) != 0);
            default: out_ready = ($urandom_range(0, 9) < 2);
          endcase
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d colors outstanding", cycles, outstanding);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int burst, random_sent;
    random_sent = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed pixels.
    // Current color already at the end color passes through unchanged.
    send_pixel(make_pixel(0, 0, 100, 10, 50, 5, 24'h123456, 24'hABCDEF, 24'hABCDEF, 1'b1));
    send_pixel(make_pixel(7, 7, 7, 7, 7, 7, 24'h000000, 24'hFFFFFF, 24'hFFFFFF, 1'b0));
    // Zero span on the major axis gives the end color, along x and along y.
    send_pixel(make_pixel(-5, 0, -5, 900, 12, 40, 24'h102030, 24'hF0E0D0, 24'h000001, 1'b1));
    send_pixel(make_pixel(0, 32767, 900, 32767, 3, -32768, 24'hFFFFFF, 24'h00FF00, 24'h0,
                          1'b0));
    // Pixel at the start gives the start color.
    send_pixel(make_pixel(-32768, 0, 32767, 0, -32768, 0, 24'hFF0000, 24'h0000FF, 24'h0,
                          1'b1));
    // Before the start and beyond the end saturate, in both directions.
    send_pixel(make_pixel(100, 0, 200, 0, 50, 0, 24'h808080, 24'h202020, 24'h0, 1'b1));
    send_pixel(make_pixel(0, 100, 0, 200, 0, 250, 24'h808080, 24'h202020, 24'h0, 1'b0));
    send_pixel(make_pixel(200, 0, 100, 0, 250, 0, 24'hFFFFFF, 24'h000000, 24'h1, 1'b1));
    send_pixel(make_pixel(0, 200, 0, 100, 0, 50, 24'hFFFFFF, 24'h000000, 24'h1, 1'b0));
    // Full coordinate range, both directions, with extreme colors.
    send_pixel(make_pixel(-32768, 0, 32767, 0, 0, 0, 24'hFFFFFF, 24'h000000, 24'h0, 1'b1));
    send_pixel(make_pixel(-32768, 0, 32767, 0, 32766, 0, 24'h000000, 24'hFFFFFF, 24'h1,
                          1'b1));
    send_pixel(make_pixel(-32768, 0, 32767, 0, 32767, 0, 24'h000000, 24'hFFFFFF, 24'h1,
                          1'b1));
    send_pixel(make_pixel(0, 32767, 0, -32768, 0, -32767, 24'h0000FF, 24'hFF0000, 24'h2,
                          1'b0));
    send_pixel(make_pixel(0, -32768, 0, 32767, 5, -32767, 24'hFFFFFF, 24'h000000, 24'h2,
                          1'b0));
    // Truncation of a repeating fraction and of the channel blend.
    send_pixel(make_pixel(0, 0, 3, 1, 1, 0, 24'h000000, 24'hFFFFFF, 24'h0000FF, 1'b1));
    send_pixel(make_pixel(0, 0, 1, 7, 0, 3, 24'h01FE7F, 24'hFE0180, 24'h0, 1'b0));
    // Negative span with a matching negative offset.
    send_pixel(make_pixel(10, 10, -10, -10, -5, -5, 24'h204060, 24'hC0A080, 24'h0, 1'b1));
    // Minor-axis coordinates are ignored, even when wild.
    send_pixel(make_pixel(-32768, 0, 32767, 64, 32767, 32, 24'hAA55AA, 24'h55AA55, 24'h0,
                          1'b0));
    send_pixel(make_pixel(0, -32768, 64, 32767, 32, 32767, 24'hAA55AA, 24'h55AA55, 24'h0,
                          1'b1));
    directed_sent = pixels_sent;

    // Random pixels in bursts. Partway through, the receiver is asked for its
    // long hold-off while the bursts go on; later the sender stops until the
    // pipeline has delivered everything it owes.
    while (random_sent < RANDOM_BEATS) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        send_pixel(random_pixel());
        random_sent++;
      end
      if (random_sent >= 150) hold_req = 1'b1;
      if (random_sent >= 400 && random_sent - burst < 400) begin
        pause_sender(1);
        wait (outstanding == 0);
      end
      pause_sender(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10));
    end
    pause_sender(1);

    wait (outstanding == 0);
    repeat (SETTLE) @(posedge clk_i);

    $display("Sent %0d pixels: %0d directed (end-color pass-through, zero spans, clamping,",
             pixels_sent, directed_sent);
    $display("full-range lines) and %0d random; %0d colors checked under back-pressure.",
             random_sent, checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### line_gradient_color_interp.f
design/lgci_pkg.sv
design/lgci_front.sv
design/lgci_div.sv
design/lgci_blend.sv
design/line_gradient_color_interp.sv
tb/sv/lgci_color_checker.sv
tb/sv/line_gradient_color_interp_tb.sv
